// ===== rtl/kmdr_pkg.sv =====
// kmdr_pkg: shared types and constants for the key matrix debounce reporter.
// Holds operation codes, register indexes, configuration defaults and the
// config/result structs. No dependencies.
`timescale 1ns / 1ps

package kmdr_pkg;

  localparam int unsigned MaxKeys     = 23;
  localparam int unsigned SampleW     = 23;
  localparam int unsigned ReportW     = 24;
  localparam int unsigned StableW     = 8;
  localparam int unsigned IdleW       = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned NumKeysDflt = 23;

  localparam logic [StableW-1:0] StableTicksRst = StableW'(5);
  localparam logic [IdleW-1:0]   IdleLimitRst   = IdleW'(500);
  localparam logic [StableW-1:0] StableMax      = '1;
  localparam logic [IdleW-1:0]   IdleMax        = '1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MAINT = 2'd1,
    OP_WAKE  = 2'd2
  } kmdr_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STABLE_TICKS = 2'd0,
    REG_IDLE_LIMIT   = 2'd1
  } kmdr_reg_e;

  typedef struct packed {
    logic [StableW-1:0] stable_ticks;
    logic [IdleW-1:0]   idle_limit;
  } kmdr_cfg_t;

  typedef struct packed {
    logic               report_valid;
    logic [ReportW-1:0] report_bits;
    logic               sleep_now;
  } kmdr_result_t;

endpackage

// ===== rtl/kmdr_core.sv =====
// kmdr_core: debounce state and per-item update logic.
// Computes one result from the staged item and commits state on advance.
// Depends on kmdr_pkg.
`timescale 1ns / 1ps

module kmdr_core
  import kmdr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NumKeysDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          op_i,
  input  logic [NUM_KEYS-1:0] sample_i,
  input  kmdr_cfg_t           cfg_i,
  output kmdr_result_t        result_o
);

  logic                awake_q, awake_d;
  logic [NUM_KEYS-1:0] committed_q, committed_d;
  logic [NUM_KEYS-1:0] candidate_q, candidate_d;
  logic                qual_q, qual_d;
  logic [StableW-1:0]  stable_q, stable_d;
  logic [IdleW-1:0]    idle_q, idle_d;
  logic                send;
  logic                sleep;

  always_comb begin
    awake_d     = awake_q;
    committed_d = committed_q;
    candidate_d = candidate_q;
    qual_d      = qual_q;
    stable_d    = stable_q;
    idle_d      = idle_q;
    send        = 1'b0;
    sleep       = 1'b0;
    unique case (kmdr_op_e'(op_i))
      OP_WAKE: begin
        awake_d  = 1'b1;
        qual_d   = 1'b0;
        stable_d = '0;
        idle_d   = '0;
      end
      OP_MAINT: begin
        send = awake_q;
      end
      OP_TICK: begin
        if (awake_q) begin
          if (qual_q) begin
            if (candidate_q == sample_i) begin
              if (stable_q != StableMax) begin
                stable_d = stable_q + 1'b1;
                if (stable_d == cfg_i.stable_ticks) begin
                  committed_d = candidate_q;
                  send        = 1'b1;
                end
              end
            end else begin
              qual_d = 1'b0;
            end
          end else if (committed_q != sample_i) begin
            candidate_d = sample_i;
            qual_d      = 1'b1;
            stable_d    = '0;
          end
          if (sample_i == '0) begin
            if (idle_q != IdleMax) begin
              idle_d = idle_q + 1'b1;
            end
            if (idle_d > cfg_i.idle_limit) begin
              awake_d = 1'b0;
              sleep   = 1'b1;
            end
          end else begin
            idle_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // key k (index k-1) lands at bit ReportW-k
  always_comb begin
    result_o.report_valid = send;
    result_o.sleep_now    = sleep;
    result_o.report_bits  = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      result_o.report_bits[ReportW-1-i] = send & committed_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awake_q     <= 1'b0;
      committed_q <= '0;
      candidate_q <= '0;
      qual_q      <= 1'b0;
      stable_q    <= '0;
      idle_q      <= '0;
    end else if (advance_i) begin
      awake_q     <= awake_d;
      committed_q <= committed_d;
      candidate_q <= candidate_d;
      qual_q      <= qual_d;
      stable_q    <= stable_d;
      idle_q      <= idle_d;
    end
  end

endmodule

// ===== rtl/key_matrix_debounce_reporter.sv =====
// key_matrix_debounce_reporter: top level with input stage, config registers
// and result register around kmdr_core. Depends on kmdr_pkg, kmdr_core.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   in      | in_valid_i / in_stall_o   | operation_i, key_sample_i
//   out     | out_valid_o / out_stall_i | report_valid_o, report_bits_o,
//           |                           | sleep_now_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the result is not stalled; each item passes through
// the input stage, then the state update into the result register.
// Reset clears all debounce state and loads register defaults; block starts
// asleep. A stalled result holds the input stage; once that stage is full the
// input stalls in the same cycle, so at most two items wait inside.
`timescale 1ns / 1ps

module key_matrix_debounce_reporter
  import kmdr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NumKeysDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [SampleW-1:0]  key_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                report_valid_o,
  output logic [ReportW-1:0]  report_bits_o,
  output logic                sleep_now_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic                s1_valid_q, s1_valid_d;
  logic [1:0]          op_q;
  logic [NUM_KEYS-1:0] sample_q;
  logic                out_valid_q, out_valid_d;
  kmdr_result_t        res_q, res_d;
  kmdr_cfg_t           cfg_q;
  logic                out_free;
  logic                s1_adv;
  logic                in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_xfer || (s1_valid_q && !s1_adv);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_ticks <= StableTicksRst;
      cfg_q.idle_limit   <= IdleLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (kmdr_reg_e'(cfg_index_i))
        REG_STABLE_TICKS: cfg_q.stable_ticks <= cfg_data_i[StableW-1:0];
        REG_IDLE_LIMIT:   cfg_q.idle_limit   <= cfg_data_i[IdleW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= operation_i;
      sample_q <= key_sample_i[NUM_KEYS-1:0];
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  kmdr_core #(
    .NUM_KEYS (NUM_KEYS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .op_i      (op_q),
    .sample_i  (sample_q),
    .cfg_i     (cfg_q),
    .result_o  (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign report_valid_o = res_q.report_valid;
  assign report_bits_o  = res_q.report_bits;
  assign sleep_now_o    = res_q.sleep_now;

endmodule
